// ===== rtl/core/nqc_pkg.sv =====
// Shared types and constants for the queen-placement completion counter.
package nqc_pkg;

  localparam int unsigned MaskW  = 32;
  localparam int unsigned CountW = 63;
  localparam int unsigned SizeW  = 5;

  localparam logic [SizeW-1:0]  BoardSizeRst = SizeW'(8);
  localparam logic [CountW-1:0] CountMax     = {CountW{1'b1}};

  // One row of the search stack.
  typedef struct packed {
    logic [MaskW-1:0] cols;
    logic [MaskW-1:0] left;
    logic [MaskW-1:0] right;
    logic [MaskW-1:0] free;
  } stack_entry_t;

  // Outcome of expanding one node of the search tree.
  typedef struct packed {
    logic             empty;
    logic             complete;
    logic [MaskW-1:0] parent_free;
    stack_entry_t     child;
  } node_res_t;

endpackage

// ===== rtl/core/nqc_stack_mem.sv =====
// Per-row search stack: one write port, one read port, registered read data.
module nqc_stack_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  nqc_pkg::stack_entry_t wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output nqc_pkg::stack_entry_t rd_data_o
);

  nqc_pkg::stack_entry_t mem_q [Depth];
  nqc_pkg::stack_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/nqc_node_unit.sv =====
// Expands one search node: lowest free column, next-row masks and free set.
module nqc_node_unit (
  input  nqc_pkg::stack_entry_t        entry_i,
  input  logic [nqc_pkg::MaskW-1:0]    board_mask_i,
  output nqc_pkg::node_res_t           res_o
);

  logic [nqc_pkg::MaskW-1:0] pick;
  logic [nqc_pkg::MaskW-1:0] nc;
  logic [nqc_pkg::MaskW-1:0] nl;
  logic [nqc_pkg::MaskW-1:0] nr;

  always_comb begin
    // Two's complement trick isolates the lowest set bit.
    pick = entry_i.free & (~entry_i.free + nqc_pkg::MaskW'(1));
    nc   = entry_i.cols | pick;
    nl   = ((entry_i.left | pick) << 1) & board_mask_i;
    nr   = (entry_i.right | pick) >> 1;

    res_o.empty       = (entry_i.free == '0);
    res_o.complete    = (nc == board_mask_i);
    res_o.parent_free = entry_i.free & ~pick;
    res_o.child.cols  = nc;
    res_o.child.left  = nl;
    res_o.child.right = nr;
    res_o.child.free  = board_mask_i & ~(nc | nl | nr);
  end

endmodule

// ===== rtl/core/nqueens_completion_counter.sv =====
// Top level: counts all completions of a partly filled queen-placement board.
//
// Usage. The input channel (in_valid_i / in_stall_o) carries one item: the
// occupied-column, left-diagonal and right-diagonal masks of a subproblem.
// The output channel (out_valid_o / out_stall_i) returns one item per input:
// the number of completions, saturating at 2^63-1. board_size_we_i writes
// board_size_i, which resets to 8; the user must write it only while idle.
// The block itself does not enforce this rule.
// Search. Each step works on the top-of-stack registers: a placement, a
// counted completion, an exhausted row or a column skipped at the depth
// bound. Each return to a parked row adds a stack memory read in the wait
// state. The size of the search tree sets the time to the result; a full
// board goes straight to the done state. Once the result is in the output
// register, the next item can be taken, even while the result waits there.
// One item is searched at a time.
// Reset clears the state machine, depth, count and the output valid; the stack
// memory is not cleared, since every row is written before it is read.
// When the receiver stalls, the finished count waits in a done state until
// the output register is free.
module nqueens_completion_counter #(
  parameter int unsigned MAX_N = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        board_size_we_i,
  input  logic [nqc_pkg::SizeW-1:0]   board_size_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [nqc_pkg::MaskW-1:0]   column_mask_i,
  input  logic [nqc_pkg::MaskW-1:0]   left_diag_mask_i,
  input  logic [nqc_pkg::MaskW-1:0]   right_diag_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [nqc_pkg::CountW-1:0]  solution_count_o
);

  localparam int unsigned AddrW  = $clog2(MAX_N);
  localparam int unsigned DepthW = $clog2(MAX_N + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [DepthW-1:0]           depth_q, depth_d;
  logic [nqc_pkg::CountW-1:0]  count_q, count_d;
  logic [nqc_pkg::SizeW-1:0]   board_size_q;
  nqc_pkg::stack_entry_t       cur_q, cur_d;
  logic                        out_valid_q, out_valid_d;
  logic [nqc_pkg::CountW-1:0]  out_count_q, out_count_d;

  logic [nqc_pkg::MaskW-1:0]   board_mask;
  logic                        in_accept;
  logic                        out_free;
  nqc_pkg::node_res_t          node_res;
  logic                        wr_en;
  logic [AddrW-1:0]            wr_addr;
  nqc_pkg::stack_entry_t       wr_data;
  logic                        rd_en;
  logic [AddrW-1:0]            rd_addr;
  nqc_pkg::stack_entry_t       rd_data;
  logic [nqc_pkg::CountW-1:0]  count_bump;

  assign board_mask = (nqc_pkg::MaskW'(1) << board_size_q) - nqc_pkg::MaskW'(1);
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign count_bump = (count_q == nqc_pkg::CountMax) ? count_q
                                                      : count_q + nqc_pkg::CountW'(1);

  nqc_node_unit u_node (
    .entry_i      (cur_q),
    .board_mask_i (board_mask),
    .res_o        (node_res)
  );

  nqc_stack_mem #(
    .Depth (MAX_N),
    .AddrW (AddrW)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    count_d     = count_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_count_d = out_count_q;
    wr_en       = 1'b0;
    wr_addr     = AddrW'(depth_q - DepthW'(1));
    wr_data     = cur_q;
    wr_data.free = node_res.parent_free;
    rd_en       = 1'b0;
    rd_addr     = AddrW'(depth_q - DepthW'(2));

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          cur_d.cols  = column_mask_i;
          cur_d.left  = left_diag_mask_i & board_mask;
          cur_d.right = right_diag_mask_i;
          cur_d.free  = board_mask & ~(column_mask_i | left_diag_mask_i | right_diag_mask_i);
          if (column_mask_i == board_mask) begin
            count_d = nqc_pkg::CountW'(1);
            depth_d = '0;
            state_d = StDone;
          end else begin
            count_d = '0;
            depth_d = DepthW'(1);
            state_d = StExec;
          end
        end
      end
      StExec: begin
        priority if (node_res.empty) begin
          depth_d = depth_q - DepthW'(1);
          if (depth_q == DepthW'(1)) begin
            state_d = StDone;
          end else begin
            // Parent row comes back from the stack memory next cycle.
            rd_en   = 1'b1;
            state_d = StWait;
          end
        end else if (node_res.complete) begin
          count_d    = count_bump;
          cur_d.free = node_res.parent_free;
        end else if (depth_q < DepthW'(MAX_N)) begin
          // Park the parent with its updated free set; the child stays in registers.
          wr_en   = 1'b1;
          cur_d   = node_res.child;
          depth_d = depth_q + DepthW'(1);
        end else begin
          cur_d.free = node_res.parent_free;
        end
      end
      StWait: begin
        cur_d   = rd_data;
        state_d = StExec;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = count_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      depth_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      board_size_q <= nqc_pkg::BoardSizeRst;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (board_size_we_i) begin
        board_size_q <= board_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign solution_count_o = out_count_q;

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(MAX_N))
    else $error("stack depth beyond its bound");

  a_exec_has_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |-> (depth_q != '0))
    else $error("search running on an empty stack");

  a_wait_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait) |=> (state_q == StExec))
    else $error("stack read wait lasted more than one cycle");

  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |=> (count_q >= $past(count_q)))
    else $error("completion count decreased during a search");
`endif

endmodule
